// File: hdl/dclk_pkg.sv
// dclk_pkg: shared types and constants for the door controller with code lock
// no dependencies; used by every module of the block

package dclk_pkg;

  localparam int CODE_W     = 14;
  localparam int TICK_W     = 8;
  localparam int DIGIT_CW   = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 14;

  localparam logic [CODE_W-1:0]   CODE_RESET   = 14'd1111;
  localparam logic [TICK_W-1:0]   TICKS_RESET  = 8'd15;
  localparam logic [7:0]          KEY_ZERO     = 8'h30;
  localparam logic [7:0]          KEY_NINE     = 8'h39;
  localparam logic [7:0]          KEY_HASH     = 8'h23;
  localparam logic [DIGIT_CW-1:0] CODE_DIGITS  = 3'd4;
  localparam logic [CODE_W-1:0]   DECIMAL_BASE = 14'd10;

  localparam logic [CFG_IDX_W-1:0] REG_LOCK_CODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE  = 1'd1;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_KEY    = 2'd1,
    OP_REMOTE = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    DOOR_CLOSED          = 3'd1,
    DOOR_CLOSING_STOPPED = 3'd2,
    DOOR_OPEN            = 3'd3,
    DOOR_OPENING_STOPPED = 3'd4,
    DOOR_OPENING         = 3'd5,
    DOOR_CLOSING         = 3'd6
  } door_t;

  typedef enum logic [1:0] {
    MOTOR_OFF   = 2'd0,
    MOTOR_OPEN  = 2'd1,
    MOTOR_CLOSE = 2'd2
  } motor_t;

  typedef enum logic [1:0] {
    EV_NONE     = 2'd0,
    EV_PRESSED  = 2'd1,
    EV_RELEASED = 2'd2
  } sw_event_t;

  typedef enum logic [1:0] {
    CODE_NONE   = 2'd0,
    CODE_ACCEPT = 2'd1,
    CODE_REJECT = 2'd2
  } code_res_t;

  typedef struct packed {
    logic      level;
    sw_event_t evt;
  } sw_status_t;

endpackage

// File: hdl/dclk_if.sv
// dclk_in_if, dclk_out_if: valid/ready channels for items and results
// no dependencies; field widths are written out as literals

interface dclk_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic       closed_switch_raw;
  logic       open_switch_raw;
  logic [7:0] key_code;

  modport source (output valid, operation, closed_switch_raw, open_switch_raw, key_code,
                  input ready);
  modport sink (input valid, operation, closed_switch_raw, open_switch_raw, key_code,
                output ready);
endinterface

interface dclk_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] door_state;
  logic [1:0] motor_drive;
  logic       closed_level;
  logic       open_level;
  logic [1:0] closed_event;
  logic [1:0] open_event;
  logic [1:0] code_result;

  modport source (output valid, door_state, motor_drive, closed_level, open_level,
                  closed_event, open_event, code_result, input ready);
  modport sink (input valid, door_state, motor_drive, closed_level, open_level,
                closed_event, open_event, code_result, output ready);
endinterface

// File: hdl/door_controller_with_code_lock.sv
// door_controller_with_code_lock: each item is held in an input register, then goes through
// one pass of logic into the result register
// throughput one item per cycle while the result is not stalled; a stalled result still lets the input register fill
// synchronous active-low reset: door closed, motor stopped, switches released,
// code cleared, configuration back to code 1111 and 15 debounce ticks

module door_controller_with_code_lock (
  input  logic                                 clk,
  input  logic                                 rst_n,
  dclk_in_if.sink                              in_if,
  dclk_out_if.source                           out_if,
  input  logic                                 cfg_we,
  input  logic [dclk_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dclk_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  logic [dclk_pkg::CODE_W-1:0] code_r;
  logic [dclk_pkg::TICK_W-1:0] ticks_r;

  logic                 s1_valid_r;
  dclk_pkg::op_t        op_r;
  logic                 closed_raw_r;
  logic                 open_raw_r;
  logic [7:0]           key_r;

  logic                 out_valid_r;
  dclk_pkg::door_t      door_out_r;
  dclk_pkg::motor_t     motor_out_r;
  logic                 closed_level_r;
  logic                 open_level_r;
  dclk_pkg::sw_event_t  closed_event_r;
  dclk_pkg::sw_event_t  open_event_r;
  dclk_pkg::code_res_t  code_result_r;

  dclk_pkg::door_t      door_r, door_nxt;
  dclk_pkg::motor_t     motor_r, motor_nxt;

  logic                 out_free;
  logic                 adv;
  logic                 act;
  dclk_pkg::sw_status_t closed_st;
  dclk_pkg::sw_status_t open_st;
  dclk_pkg::code_res_t  code_res;

  assign out_free    = !out_valid_r || out_if.ready;
  assign adv         = s1_valid_r && out_free;
  assign in_if.ready = !s1_valid_r || out_free;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_r  <= dclk_pkg::CODE_RESET;
      ticks_r <= dclk_pkg::TICKS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dclk_pkg::REG_LOCK_CODE: code_r  <= cfg_wdata;
        dclk_pkg::REG_DEBOUNCE:  ticks_r <= cfg_wdata[dclk_pkg::TICK_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      s1_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      op_r         <= dclk_pkg::op_t'(in_if.operation);
      closed_raw_r <= in_if.closed_switch_raw;
      open_raw_r   <= in_if.open_switch_raw;
      key_r        <= in_if.key_code;
    end
  end

  dclk_debounce u_closed_sw (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (adv && op_r == dclk_pkg::OP_TICK),
    .raw    (closed_raw_r),
    .reload (ticks_r),
    .status (closed_st)
  );

  dclk_debounce u_open_sw (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (adv && op_r == dclk_pkg::OP_TICK),
    .raw    (open_raw_r),
    .reload (ticks_r),
    .status (open_st)
  );

  dclk_code u_code (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (adv && op_r == dclk_pkg::OP_KEY),
    .key        (key_r),
    .lock_code  (code_r),
    .result     (code_res)
  );

  assign act = adv && (op_r == dclk_pkg::OP_REMOTE || code_res == dclk_pkg::CODE_ACCEPT);

  // door state machine
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      door_r  <= dclk_pkg::DOOR_CLOSED;
      motor_r <= dclk_pkg::MOTOR_OFF;
    end else begin
      door_r  <= door_nxt;
      motor_r <= motor_nxt;
    end
  end

  always_comb begin
    door_nxt  = door_r;
    motor_nxt = motor_r;
    if (act) begin
      unique case (door_r)
        dclk_pkg::DOOR_OPENING: begin
          door_nxt  = dclk_pkg::DOOR_OPENING_STOPPED;
          motor_nxt = dclk_pkg::MOTOR_OFF;
        end
        dclk_pkg::DOOR_CLOSING: begin
          door_nxt  = dclk_pkg::DOOR_CLOSING_STOPPED;
          motor_nxt = dclk_pkg::MOTOR_OFF;
        end
        dclk_pkg::DOOR_OPEN, dclk_pkg::DOOR_OPENING_STOPPED: begin
          door_nxt  = dclk_pkg::DOOR_CLOSING;
          motor_nxt = dclk_pkg::MOTOR_CLOSE;
        end
        default: begin
          door_nxt  = dclk_pkg::DOOR_OPENING;
          motor_nxt = dclk_pkg::MOTOR_OPEN;
        end
      endcase
    end
    // closed first, open last
    if (closed_st.evt == dclk_pkg::EV_PRESSED) begin
      door_nxt  = dclk_pkg::DOOR_CLOSED;
      motor_nxt = dclk_pkg::MOTOR_OFF;
    end
    if (open_st.evt == dclk_pkg::EV_PRESSED) begin
      door_nxt  = dclk_pkg::DOOR_OPEN;
      motor_nxt = dclk_pkg::MOTOR_OFF;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      door_out_r     <= door_nxt;
      motor_out_r    <= motor_nxt;
      closed_level_r <= closed_st.level;
      open_level_r   <= open_st.level;
      closed_event_r <= closed_st.evt;
      open_event_r   <= open_st.evt;
      code_result_r  <= code_res;
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.door_state   = door_out_r;
  assign out_if.motor_drive  = motor_out_r;
  assign out_if.closed_level = closed_level_r;
  assign out_if.open_level   = open_level_r;
  assign out_if.closed_event = closed_event_r;
  assign out_if.open_event   = open_event_r;
  assign out_if.code_result  = code_result_r;

endmodule

// File: hdl/dclk_debounce.sv
// dclk_debounce: countdown debouncer for one limit switch
// depends on dclk_pkg

module dclk_debounce (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          raw,
  input  logic [dclk_pkg::TICK_W-1:0]   reload,
  output dclk_pkg::sw_status_t          status
);

  logic                        pending_r, pending_nxt;
  logic                        stable_r, stable_nxt;
  logic                        waiting_r, waiting_nxt;
  logic [dclk_pkg::TICK_W-1:0] count_r, count_nxt;
  dclk_pkg::sw_event_t         evt;

  always_comb begin
    pending_nxt = pending_r;
    stable_nxt  = stable_r;
    waiting_nxt = waiting_r;
    count_nxt   = count_r;
    evt         = dclk_pkg::EV_NONE;
    if (en) begin
      if (raw != pending_r) begin
        count_nxt   = reload;
        pending_nxt = raw;
        waiting_nxt = 1'b1;
      end else if (count_r != '0) begin
        count_nxt = count_r - 1'b1;
      end else if (waiting_r) begin
        stable_nxt  = pending_r;
        waiting_nxt = 1'b0;
        evt = pending_r ? dclk_pkg::EV_RELEASED : dclk_pkg::EV_PRESSED;
      end
    end
  end

  assign status.level = stable_nxt;
  assign status.evt   = evt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 1'b1;
      stable_r  <= 1'b1;
      waiting_r <= 1'b0;
      count_r   <= '0;
    end else begin
      pending_r <= pending_nxt;
      stable_r  <= stable_nxt;
      waiting_r <= waiting_nxt;
      count_r   <= count_nxt;
    end
  end

endmodule

// File: hdl/dclk_code.sv
// dclk_code: four digit code entry and check on '#'
// depends on dclk_pkg

module dclk_code (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic [7:0]                    key,
  input  logic [dclk_pkg::CODE_W-1:0]   lock_code,
  output dclk_pkg::code_res_t           result
);

  logic [dclk_pkg::CODE_W-1:0]   value_r, value_nxt;
  logic [dclk_pkg::DIGIT_CW-1:0] digits_r, digits_nxt;
  logic [dclk_pkg::CODE_W-1:0]   base;
  logic [dclk_pkg::DIGIT_CW-1:0] base_digits;
  logic [dclk_pkg::CODE_W-1:0]   digit;
  logic                          restart;

  assign restart     = (digits_r >= dclk_pkg::CODE_DIGITS);
  assign base        = restart ? '0 : value_r;
  assign base_digits = restart ? '0 : digits_r;
  // ascii digits carry their value in the low nibble
  assign digit       = {{(dclk_pkg::CODE_W-4){1'b0}}, key[3:0]};

  always_comb begin
    value_nxt  = value_r;
    digits_nxt = digits_r;
    result     = dclk_pkg::CODE_NONE;
    if (en) begin
      if (key >= dclk_pkg::KEY_ZERO && key <= dclk_pkg::KEY_NINE) begin
        digits_nxt = base_digits + 1'b1;
        value_nxt  = base * dclk_pkg::DECIMAL_BASE + digit;
      end else if (key == dclk_pkg::KEY_HASH) begin
        if (digits_r == dclk_pkg::CODE_DIGITS && value_r == lock_code) begin
          result = dclk_pkg::CODE_ACCEPT;
        end else begin
          result = dclk_pkg::CODE_REJECT;
        end
        value_nxt  = '0;
        digits_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      value_r  <= '0;
      digits_r <= '0;
    end else begin
      value_r  <= value_nxt;
      digits_r <= digits_nxt;
    end
  end

endmodule

// File: hdl/dclk_checker.sv
// dclk_checker: port-level assertions for door_controller_with_code_lock
// depends on dclk_pkg; bound to the top level below

module dclk_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] door_state,
  input logic [1:0] motor_drive,
  input logic       closed_level,
  input logic       open_level,
  input logic [1:0] closed_event,
  input logic [1:0] open_event,
  input logic [1:0] code_result
);

  // result held until transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // motor runs exactly when the door is moving in that direction
  a_motor_door: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      ((door_state == dclk_pkg::DOOR_OPENING) == (motor_drive == dclk_pkg::MOTOR_OPEN)) &&
      ((door_state == dclk_pkg::DOOR_CLOSING) == (motor_drive == dclk_pkg::MOTOR_CLOSE)))
    else $error("motor drive disagrees with door state");

  // switch events come from ticks, code results from keys
  a_event_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && code_result != dclk_pkg::CODE_NONE |->
      closed_event == dclk_pkg::EV_NONE && open_event == dclk_pkg::EV_NONE)
    else $error("switch event alongside code result");

  a_event_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      (closed_event != dclk_pkg::EV_PRESSED || !closed_level) &&
      (closed_event != dclk_pkg::EV_RELEASED || closed_level) &&
      (open_event != dclk_pkg::EV_PRESSED || !open_level) &&
      (open_event != dclk_pkg::EV_RELEASED || open_level))
    else $error("switch event disagrees with debounced level");

endmodule

bind door_controller_with_code_lock dclk_checker u_dclk_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_if.valid),
  .out_ready    (out_if.ready),
  .door_state   (out_if.door_state),
  .motor_drive  (out_if.motor_drive),
  .closed_level (out_if.closed_level),
  .open_level   (out_if.open_level),
  .closed_event (out_if.closed_event),
  .open_event   (out_if.open_event),
  .code_result  (out_if.code_result)
);

// File: test/door_controller_with_code_lock_test.sv
// door_controller_with_code_lock_test: drives ticks, keys and remote requests into the door
// controller, predicts every result and compares it field by field
// depends on dclk_pkg, dclk_in_if, dclk_out_if and door_controller_with_code_lock

module door_controller_with_code_lock_test;
  import dclk_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;

  typedef struct {
    logic       pending;
    logic       stable;
    logic [7:0] countdown;
    logic       waiting;
  } switch_filter_t;

  typedef struct {
    door_t     door;
    motor_t    motor;
    logic      closed_level;
    logic      open_level;
    sw_event_t closed_ev;
    sw_event_t open_ev;
    code_res_t code;
  } door_status_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  dclk_in_if in_ch();
  dclk_out_if out_ch();

  door_controller_with_code_lock i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch.sink),
    .out_if    (out_ch.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  door_status_t pending_status[$];
  door_t door_now;
  motor_t motor_now;
  switch_filter_t closed_filter;
  switch_filter_t open_filter;
  logic [CODE_W-1:0] code_value;
  logic [DIGIT_CW-1:0] code_digits;
  logic [CODE_W-1:0] code_setting;
  logic [TICK_W-1:0] ticks_setting;

  logic closed_raw = 1'b1;
  logic open_raw = 1'b1;
  int errors = 0;
  int sent = 0;
  int stall_cycles = 0;
  int hold_len = 0;
  bit in_idle_on = 1'b1;
  bit out_idle_on = 1'b1;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  task automatic filter_switch(inout switch_filter_t f, input logic raw, output sw_event_t ev);
    ev = EV_NONE;
    if (raw != f.pending) begin
      f.countdown = ticks_setting;
      f.pending = raw;
      f.waiting = 1'b1;
    end else if (f.countdown != 0) begin
      f.countdown = f.countdown - 1'b1;
    end else if (f.waiting) begin
      f.stable = f.pending;
      f.waiting = 1'b0;
      ev = f.stable ? EV_RELEASED : EV_PRESSED;
    end
  endtask

  task automatic actuate_door();
    case (door_now)
      DOOR_OPENING: begin
        motor_now = MOTOR_OFF;
        door_now = DOOR_OPENING_STOPPED;
      end
      DOOR_CLOSING: begin
        motor_now = MOTOR_OFF;
        door_now = DOOR_CLOSING_STOPPED;
      end
      DOOR_OPEN, DOOR_OPENING_STOPPED: begin
        motor_now = MOTOR_CLOSE;
        door_now = DOOR_CLOSING;
      end
      default: begin
        motor_now = MOTOR_OPEN;
        door_now = DOOR_OPENING;
      end
    endcase
  endtask

  task automatic reset_door_model();
    door_now = DOOR_CLOSED;
    motor_now = MOTOR_OFF;
    closed_filter = '{pending: 1'b1, stable: 1'b1, countdown: 8'd0, waiting: 1'b0};
    open_filter = closed_filter;
    code_value = '0;
    code_digits = '0;
    code_setting = CODE_RESET;
    ticks_setting = TICKS_RESET;
  endtask

  task automatic compute_door_status(op_t op, logic c_raw, logic o_raw, logic [7:0] key);
    door_status_t s;
    s.closed_ev = EV_NONE;
    s.open_ev = EV_NONE;
    s.code = CODE_NONE;
    case (op)
      OP_TICK: begin
        filter_switch(closed_filter, c_raw, s.closed_ev);
        filter_switch(open_filter, o_raw, s.open_ev);
        if (s.closed_ev == EV_PRESSED) begin
          motor_now = MOTOR_OFF;
          door_now = DOOR_CLOSED;
        end
        if (s.open_ev == EV_PRESSED) begin
          motor_now = MOTOR_OFF;
          door_now = DOOR_OPEN;
        end
      end
      OP_KEY: begin
        if (key >= KEY_ZERO && key <= KEY_NINE) begin
          if (code_digits >= CODE_DIGITS) begin
            code_value = '0;
            code_digits = '0;
          end
          code_digits = code_digits + 1'b1;
          code_value = code_value * DECIMAL_BASE + CODE_W'(key - KEY_ZERO);
        end else if (key == KEY_HASH) begin
          if (code_digits == CODE_DIGITS && code_value == code_setting) begin
            s.code = CODE_ACCEPT;
            actuate_door();
          end else begin
            s.code = CODE_REJECT;
          end
          code_value = '0;
          code_digits = '0;
        end
      end
      OP_REMOTE: actuate_door();
      default: ;
    endcase
    s.door = door_now;
    s.motor = motor_now;
    s.closed_level = closed_filter.stable;
    s.open_level = open_filter.stable;
    pending_status.push_back(s);
  endtask

  task automatic send_item(op_t op, logic c_raw, logic o_raw, logic [7:0] key);
    int gap;
    gap = in_idle_on ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.operation <= op;
    in_ch.closed_switch_raw <= c_raw;
    in_ch.open_switch_raw <= o_raw;
    in_ch.key_code <= key;
    do @(posedge clk); while (!in_ch.ready);
    compute_door_status(op, c_raw, o_raw, key);
    sent++;
  endtask

  // stop offering items and let every outstanding result come back
  task automatic finish_phase();
    in_ch.valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(logic [CODE_W-1:0] code, logic [TICK_W-1:0] ticks);
    cfg_we <= 1'b1;
    cfg_index <= REG_LOCK_CODE;
    cfg_wdata <= code;
    @(posedge clk);
    cfg_index <= REG_DEBOUNCE;
    cfg_wdata <= CFG_DATA_W'(ticks);
    @(posedge clk);
    cfg_we <= 1'b0;
    code_setting = code;
    ticks_setting = ticks;
  endtask

  task automatic send_code_attempt();
    logic [7:0] keys[$];
    int kind;
    int div;
    kind = $urandom_range(0, 7);
    div = 1000;
    if (kind == 6) repeat (4) keys.push_back(KEY_ZERO + 8'($urandom_range(0, 9)));
    repeat (4) begin
      keys.push_back(KEY_ZERO + 8'((int'(code_setting) / div) % 10));
      div = div / 10;
    end
    case (kind)
      4: keys[$urandom_range(0, 3)] = KEY_ZERO + 8'($urandom_range(0, 9));
      5: void'(keys.pop_back());
      7: keys.push_back(KEY_ZERO + 8'($urandom_range(0, 9)));
      default: ;
    endcase
    keys.push_back(KEY_HASH);
    foreach (keys[k]) send_item(OP_KEY, 1'($urandom), 1'($urandom), keys[k]);
  endtask

  task automatic random_items(int count);
    int first;
    int pick;
    int flip_permille;
    logic [7:0] key;
    first = sent;
    flip_permille = (ticks_setting > 8'd20) ? 3 : 120;
    while (sent - first < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        if ($urandom_range(0, 999) < flip_permille) closed_raw = ~closed_raw;
        if ($urandom_range(0, 999) < flip_permille) open_raw = ~open_raw;
        send_item(OP_TICK, closed_raw, open_raw, 8'($urandom));
      end else if (pick < 65) begin
        send_code_attempt();
      end else if (pick < 75) begin
        send_item(OP_REMOTE, 1'($urandom), 1'($urandom), 8'($urandom));
      end else if (pick < 90) begin
        key = $urandom_range(0, 1) ? KEY_ZERO + 8'($urandom_range(0, 9)) : 8'($urandom);
        send_item(OP_KEY, 1'($urandom), 1'($urandom), key);
      end else if (pick < 95) begin
        send_item(OP_NONE, 1'($urandom), 1'($urandom), 8'($urandom));
      end else begin
        send_item(OP_KEY, 1'($urandom), 1'($urandom), KEY_HASH);
      end
    end
  endtask

  task automatic test_remote_actuate();
    send_item(OP_TICK, 1'b1, 1'b1, 8'h00);
    send_item(OP_NONE, 1'b0, 1'b0, 8'hFF);
    repeat (5) send_item(OP_REMOTE, 1'b1, 1'b1, 8'h00);
  endtask

  task automatic test_code_entry();
    repeat (4) send_item(OP_KEY, 1'b1, 1'b1, KEY_ZERO + 8'd1);
    send_item(OP_KEY, 1'b1, 1'b1, KEY_HASH);
    send_item(OP_KEY, 1'b0, 1'b1, KEY_NINE);
    send_item(OP_KEY, 1'b1, 1'b0, KEY_ZERO);
    send_item(OP_KEY, 1'b1, 1'b1, KEY_HASH);
    repeat (5) send_item(OP_KEY, 1'b1, 1'b1, KEY_ZERO + 8'd1);
    send_item(OP_KEY, 1'b1, 1'b1, KEY_HASH);
    send_item(OP_KEY, 1'b1, 1'b1, 8'h00);
    send_item(OP_KEY, 1'b1, 1'b1, 8'hFF);
  endtask

  // zero debounce, both limit switches pressed in one tick, then released
  task automatic test_limit_switches();
    finish_phase();
    set_config(14'h3FFF, 8'd0);
    repeat (2) send_item(OP_TICK, 1'b0, 1'b0, 8'h00);
    repeat (2) send_item(OP_TICK, 1'b1, 1'b1, 8'h00);
  endtask

  task automatic test_output_stall();
    finish_phase();
    hold_len = 80;
    in_idle_on = 1'b0;
    repeat (15) begin
      send_item(OP_TICK, closed_raw, open_raw, 8'($urandom));
      send_item(OP_REMOTE, 1'($urandom), 1'($urandom), 8'($urandom));
    end
    in_idle_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    logic [CODE_W-1:0] code;
    logic [TICK_W-1:0] ticks;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin
          code = '0;
          ticks = 8'd0;
        end
        1: begin
          code = 14'd9999;
          ticks = 8'd1;
        end
        2: begin
          code = 14'h3FFF;
          ticks = 8'd2;
        end
        3: begin
          code = CODE_W'($urandom_range(0, 9999));
          ticks = 8'hFF;
        end
        default: begin
          code = CODE_W'($urandom_range(0, 9999));
          ticks = TICK_W'($urandom_range(0, 6));
        end
      endcase
      finish_phase();
      set_config(code, ticks);
      in_idle_on = (phase % 3) != 1;
      out_idle_on = (phase % 4) != 2;
      random_items(200);
    end
    in_idle_on = 1'b1;
    out_idle_on = 1'b1;
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      errors++;
      $display("%0t %s expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : result_check
    door_status_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_status.size() == 0) begin
        errors++;
        $display("%0t unexpected result, door_state %0d", $time, out_ch.door_state);
      end else begin
        want = pending_status.pop_front();
        check_field("door_state", int'(want.door), int'(out_ch.door_state));
        check_field("motor_drive", int'(want.motor), int'(out_ch.motor_drive));
        check_field("closed_level", int'(want.closed_level), int'(out_ch.closed_level));
        check_field("open_level", int'(want.open_level), int'(out_ch.open_level));
        check_field("closed_event", int'(want.closed_ev), int'(out_ch.closed_event));
        check_field("open_event", int'(want.open_ev), int'(out_ch.open_event));
        check_field("code_result", int'(want.code), int'(out_ch.code_result));
      end
    end
  end

  initial begin : result_sink
    int gap;
    out_ch.ready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (hold_len > 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold_len) @(posedge clk);
        hold_len = 0;
      end
      gap = out_idle_on ? $urandom_range(0, 11) : 0;
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= REG_LOCK_CODE;
    cfg_wdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.operation <= OP_TICK;
    in_ch.closed_switch_raw <= 1'b1;
    in_ch.open_switch_raw <= 1'b1;
    in_ch.key_code <= 8'h00;
    reset_door_model();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_remote_actuate();
    test_code_entry();
    test_limit_switches();
    test_output_stall();
    test_random_traffic();
    finish_phase();
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
